// ===== rtl/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types and constants for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } t_out_word;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic       load;    // copy chaining words into working vars
        logic       round;   // execute one round with w_t
        logic [6:0] rnd;     // round number 0..79
    } t_rnd_ctl;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] KTAB [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== rtl/sha512_round.sv =====
// ----------------------------------------------------------------------------
// sha512_round
// Working variables a..h and one SHA-512 round per cycle while i_ctl.round is set.
// ----------------------------------------------------------------------------
module sha512_round
    import sha512_pkg::*;
(
    input  logic        i_clk,
    input  t_rnd_ctl    i_ctl,
    input  logic [63:0] i_w,
    input  logic [63:0] i_init [0:7],
    output logic [63:0] o_v    [0:7]
);

    logic [63:0] r_v [0:7];
    logic [63:0] t1, t2;

    // round function
    always_comb begin
        t1 = r_v[7] + (ror64(r_v[4], 14) ^ ror64(r_v[4], 18) ^ ror64(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + KTAB[i_ctl.rnd] + i_w;
        t2 = (ror64(r_v[0], 28) ^ ror64(r_v[0], 34) ^ ror64(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_init;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_v = r_v;

endmodule

// ===== rtl/sha512_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 over a byte stream, digest out as eight 64-bit words.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while a block fills. Bytes are packed into
// 64-bit words as they arrive and each full word goes into a 16-entry
// schedule memory. When the 128th byte of a block arrives the input stalls:
// S_LOAD loads the working variables, 80 rounds follow (rounds 0..15 each
// do read, capture, round; rounds 16..79 each do four memory reads for t-2,
// t-15, t-7 and t-16, the schedule update with write-back, then the round),
// and S_ADD adds into the chaining words. End of message writes a padded
// block word by word and compresses it; a second padded block follows when
// the message leaves 16 or fewer free bytes, and a message that ends exactly
// on a block boundary first compresses that full block. The eight digest
// words then leave one per accepted word while input stays stalled. A
// message whose bit count wraps 128 bits gives one word with length_error
// instead.
// ----------------------------------------------------------------------------
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    localparam logic [3:0] S_IN   = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;  // read schedule words
    localparam logic [3:0] S_RND  = 4'd2;  // round using read data
    localparam logic [3:0] S_ADD  = 4'd3;  // add into chaining words
    localparam logic [3:0] S_PAD  = 4'd4;  // build padded block word by word
    localparam logic [3:0] S_OUT  = 4'd5;
    localparam logic [3:0] S_LOAD = 4'd6;
    localparam logic [3:0] S_RD2  = 4'd7;  // schedule update with write-back

    // schedule memory: 16 x 64, one write, one registered read
    logic [63:0] w_mem [0:15];
    logic [3:0]  w_waddr, w_raddr;
    logic [63:0] w_wdata, w_rdata;
    logic        w_we;

    always_ff @(posedge i_clk) begin
        if (w_we) w_mem[w_waddr] <= w_wdata;
        w_rdata <= w_mem[w_raddr];
    end

    logic [3:0]   r_st;
    logic [63:0]  r_h [0:7];
    logic [63:0]  r_cnt_lo, r_cnt_hi;
    logic         r_ovf;
    logic [6:0]   r_pos;
    logic [63:0]  r_acc;          // bytes packing into a word
    logic [6:0]   r_rnd;
    logic [63:0]  r_wt;           // current schedule word
    logic [63:0]  r_w2, r_w15, r_w7; // operands for schedule update
    logic [1:0]   r_sub;          // sub-step within schedule read
    logic         r_fin;          // padding in progress
    logic         r_mark;         // 0x80 marker already placed
    logic         r_extra;        // second padded block, no marker
    logic         r_lenblk;       // current padded block carries length
    logic [3:0]   r_pw;           // pad word index
    logic [2:0]   r_oi;
    logic         r_err;
    logic [63:0]  r_bits_lo, r_bits_hi;
    t_rnd_ctl     ctl;
    logic [63:0]  v [0:7];

    sha512_round u_rnd (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_w   (r_wt),
        .i_init(r_h),
        .o_v   (v)
    );

    logic acc_in, take_byte;
    logic [63:0] acc_n, s0, s1;
    assign acc_in    = i_valid && !o_stall;
    assign take_byte = acc_in && i_data.byte_present && !r_ovf;
    assign acc_n     = {r_acc[55:0], i_data.data_byte};
    assign o_stall   = (r_st != S_IN);
    assign s1 = ror64(r_w2, 19) ^ ror64(r_w2, 61) ^ (r_w2 >> 6);
    assign s0 = ror64(r_w15, 1) ^ ror64(r_w15, 8) ^ (r_w15 >> 7);

    // memory port and round control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[6:3];
        w_wdata = acc_n;
        w_raddr = r_rnd[3:0];
        ctl     = '{load: 1'b0, round: 1'b0, rnd: r_rnd};
        case (r_st)
            S_IN: begin
                w_we = take_byte && (r_pos[2:0] == 3'd7);
            end
            S_LOAD: ctl.load = 1'b1;
            S_RD: begin
                // rounds 0..15 read directly; later read t-2, t-15, t-7, t-16
                case (r_sub)
                    2'd0: w_raddr = r_rnd[3:0] - 4'd2;
                    2'd1: w_raddr = r_rnd[3:0] - 4'd15;
                    2'd2: w_raddr = r_rnd[3:0] - 4'd7;
                    default: w_raddr = r_rnd[3:0];
                endcase
            end
            S_RD2: begin
                w_we    = (r_rnd >= 7'd16);
                w_waddr = r_rnd[3:0];
                w_wdata = s1 + r_w7 + s0 + w_rdata;
            end
            S_RND: ctl.round = 1'b1;
            S_PAD: begin
                // words below the marker word already hold message bytes
                w_we    = r_extra || (r_pw >= r_pos[6:3]);
                w_waddr = r_pw;
                w_wdata = 64'd0;
                if (r_lenblk && r_pw == 4'd14) w_wdata = r_bits_hi;
                if (r_lenblk && r_pw == 4'd15) w_wdata = r_bits_lo;
                if (!r_extra && r_pw == r_pos[6:3]) begin
                    // word holding the 0x80 marker: stored bytes then 80, zeros
                    w_wdata = (r_acc << (8 * (4'd8 - {1'b0, r_pos[2:0]})))
                            | (64'h80 << (8 * (4'd7 - {1'b0, r_pos[2:0]})));
                    if (r_pos[2:0] == 3'd0) w_wdata = 64'h8000_0000_0000_0000;
                end
            end
            default: ;
        endcase
    end

    logic [63:0] cl_n;
    logic        ch_n;
    always_comb begin
        {ch_n, cl_n} = {1'b0, r_cnt_lo} + 65'd8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IN;
            r_h      <= IV;
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_fin    <= 1'b0;
            r_mark   <= 1'b0;
            r_extra  <= 1'b0;
            r_lenblk <= 1'b0;
            r_err    <= 1'b0;
            r_oi     <= '0;
            r_rnd    <= '0;
            r_sub    <= '0;
            r_pw     <= '0;
        end else begin
            case (r_st)
                S_IN: if (acc_in) begin
                    if (take_byte) begin
                        r_acc    <= acc_n;
                        r_pos    <= r_pos + 7'd1;
                        r_cnt_lo <= cl_n;
                        if (ch_n) begin
                            r_cnt_hi <= r_cnt_hi + 64'd1;
                            if (r_cnt_hi == '1) r_ovf <= 1'b1;
                        end
                    end
                    if (i_data.end_of_message) begin
                        r_fin <= 1'b1;
                        r_bits_lo <= take_byte ? cl_n : r_cnt_lo;
                        r_bits_hi <= (take_byte && ch_n) ? r_cnt_hi + 64'd1 : r_cnt_hi;
                    end
                    if (i_data.end_of_message &&
                        (r_ovf || (take_byte && ch_n && r_cnt_hi == '1))) begin
                        r_err <= 1'b1;
                        r_st  <= S_OUT;
                    end else if (take_byte && r_pos == 7'd127) begin
                        // full block; on end of message the marker opens a new one
                        r_mark <= 1'b0;
                        r_st   <= S_LOAD;
                    end else if (i_data.end_of_message) begin
                        // marker word needs prior bytes of the word
                        r_pw     <= '0;
                        r_mark   <= 1'b1;
                        r_extra  <= 1'b0;
                        r_lenblk <= ((take_byte ? r_pos + 7'd1 : r_pos) < 7'd112);
                        r_st <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_pw <= r_pw + 4'd1;
                    if (r_pw == 4'd15) r_st <= S_LOAD;
                end
                S_LOAD: begin
                    r_rnd <= '0;
                    r_sub <= 2'd3;
                    r_st  <= S_RD;
                end
                S_RD: begin
                    // pipeline reads: capture previous data by sub step
                    r_sub <= r_sub + 2'd1;
                    case (r_sub)
                        2'd0: ;
                        2'd1: r_w2  <= w_rdata;
                        2'd2: r_w15 <= w_rdata;
                        default: begin
                            r_w7 <= w_rdata;
                            r_st <= S_RD2;
                        end
                    endcase
                end
                S_RD2: begin
                    r_wt <= (r_rnd >= 7'd16) ? (s1 + r_w7 + s0 + w_rdata) : w_rdata;
                    r_st <= S_RND;
                end
                S_RND: begin
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) begin
                        r_st <= S_ADD;
                    end else begin
                        r_sub <= (r_rnd + 7'd1 >= 7'd16) ? 2'd0 : 2'd3;
                        r_st  <= S_RD;
                    end
                end
                S_ADD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + v[k];
                    if (!r_fin) begin
                        r_st <= S_IN;
                    end else if (!r_mark) begin
                        // message ended on a block boundary: marker and length block
                        r_mark   <= 1'b1;
                        r_extra  <= 1'b0;
                        r_lenblk <= 1'b1;
                        r_pw     <= '0;
                        r_st     <= S_PAD;
                    end else if (!r_lenblk) begin
                        // marker block done, length block follows
                        r_extra  <= 1'b1;
                        r_lenblk <= 1'b1;
                        r_pw     <= '0;
                        r_st     <= S_PAD;
                    end else begin
                        r_oi <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) begin
                    if (r_err || r_oi == 3'd7) begin
                        r_st     <= S_IN;
                        r_h      <= IV;
                        r_cnt_lo <= '0;
                        r_cnt_hi <= '0;
                        r_ovf    <= 1'b0;
                        r_pos    <= '0;
                        r_fin    <= 1'b0;
                        r_err    <= 1'b0;
                        r_oi     <= '0;
                    end else begin
                        r_oi <= r_oi + 3'd1;
                    end
                end
                default: r_st <= S_IN;
            endcase
        end
    end

    assign o_valid = (r_st == S_OUT);
    assign o_data  = '{digest_word : r_err ? 64'd0 : r_h[r_oi],
                       word_index  : r_oi,
                       last_word   : r_err || r_oi == 3'd7,
                       length_error: r_err};

endmodule
